// File: hw/rtl/ap2x2_pkg.sv
`timescale 1ns / 1ps

package ap2x2_pkg;

   // widths of the count registers on the csr port
   localparam int CNT_BITS = 11;

   // largest row count taken; larger writes saturate to it
   localparam int ROW_LIMIT = 1024;
   localparam int ROW_BITS  = $clog2(ROW_LIMIT) + 1;

   localparam int DEFAULT_MAX_COLUMNS = 1024;
   localparam int DEFAULT_SAMPLE_BITS = 16;

   // register indexes on the csr port
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ROW_COUNT    = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COLUMN_COUNT = 1'd1;

   localparam logic [CNT_BITS-1:0] ROW_COUNT_RESET    = 11'd2;
   localparam logic [CNT_BITS-1:0] COLUMN_COUNT_RESET = 11'd2;

endpackage

// File: hw/rtl/ap2x2_half_row_ram.sv
`timescale 1ns / 1ps

module ap2x2_half_row_ram
   import ap2x2_pkg::*;
#(
   parameter int DEPTH      = DEFAULT_MAX_COLUMNS / 2,
   parameter int ADDR_BITS  = $clog2(DEFAULT_MAX_COLUMNS / 2),
   parameter int DATA_BITS  = DEFAULT_SAMPLE_BITS + 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next enabled read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/average_pool_2x2.sv
`timescale 1ns / 1ps

// 2x2 average pooling with stride 2 over a raster stream of signed samples.
// Set row and column counts through the csr port (any write restarts the
// matrix); each 2x2 block yields its sum divided by four, truncated toward
// zero, and a trailing odd row or column is dropped. One sample is taken
// every cycle while the result side is ready; the sample that completes a
// block passes through the half-row buffer read (stage 1) and then the
// final add into the output register before its result leaves. The
// half-row buffer is a MAX_COLUMNS/2 entry memory holding pair sums of the
// last even row; it needs no clearing pass.

module average_pool_2x2
   import ap2x2_pkg::*;
#(
   parameter int MAX_COLUMNS = DEFAULT_MAX_COLUMNS,
   parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // csr port
   input  logic                                    csr_we,
   input  logic [CSR_INDEX_BITS-1:0]               csr_index,
   input  logic [CNT_BITS-1:0]                     csr_wdata,
   // sample stream
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]         req_tdata,  // sample
   // result stream
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]         rsp_tdata,  // average
   output logic                                    rsp_tlast,  // row_done
   output logic                                    rsp_tuser   // matrix_done
);

   localparam int DATA_BYTES_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int HALF_DEPTH      = (MAX_COLUMNS / 2 > 0) ? MAX_COLUMNS / 2 : 1;
   localparam int ADDR_BITS       = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
   localparam int COL_BITS_RAW    = $clog2(MAX_COLUMNS) + 1;
   localparam int COL_BITS        = (COL_BITS_RAW > CNT_BITS) ? COL_BITS_RAW : CNT_BITS;
   localparam int PAIR_BITS       = SAMPLE_BITS + 1;
   localparam int SUM_BITS        = SAMPLE_BITS + 2;

   // configuration, stored already saturated
   logic [ROW_BITS-1:0]  rows_ff, rows_in;
   logic [COL_BITS-1:0]  cols_ff, cols_in;

   // stream position and even-column sample
   logic [ROW_BITS-1:0]    row_ff, row_in;
   logic [COL_BITS-1:0]    col_ff, col_in;
   logic [SAMPLE_BITS-1:0] first_ff, first_in;

   // stage 1: buffer read in flight
   logic                 s1_valid_ff, s1_valid_in;
   logic [PAIR_BITS-1:0] s1_pair_ff, s1_pair_in;
   logic                 s1_row_done_ff, s1_row_done_in;
   logic                 s1_mat_done_ff, s1_mat_done_in;

   // output register
   logic                   out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0] out_avg_ff, out_avg_in;
   logic                   out_row_done_ff, out_row_done_in;
   logic                   out_mat_done_ff, out_mat_done_in;

   logic                   advance;
   logic                   accept;
   logic [SAMPLE_BITS-1:0] sample;
   logic [PAIR_BITS-1:0]   pair;
   logic                   odd_col;
   logic                   odd_row;
   logic                   buf_wr;
   logic                   buf_rd;
   logic [ADDR_BITS-1:0]   buf_addr;
   logic [PAIR_BITS-1:0]   buf_data;
   logic [COL_BITS-1:0]    last_col;
   logic [ROW_BITS-1:0]    last_row;
   logic                   row_done;
   logic [SUM_BITS-1:0]    sum4;
   logic [SUM_BITS-1:0]    biased;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   assign sample   = req_tdata[SAMPLE_BITS-1:0];
   assign odd_col  = col_ff[0];
   assign odd_row  = row_ff[0];
   assign pair     = {first_ff[SAMPLE_BITS-1], first_ff} + {sample[SAMPLE_BITS-1], sample};
   assign buf_addr = col_ff[ADDR_BITS:1];
   assign buf_wr   = accept && odd_col && !odd_row;
   assign buf_rd   = accept && odd_col && odd_row;

   assign last_col = (cols_ff & ~COL_BITS'(1)) - COL_BITS'(1);
   assign last_row = (rows_ff & ~ROW_BITS'(1)) - ROW_BITS'(1);
   assign row_done = (col_ff == last_col);

   ap2x2_half_row_ram #(
      .DEPTH     (HALF_DEPTH),
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (PAIR_BITS)
   ) u_half_row_ram (
      .clock   (clock),
      .wr_en   (buf_wr),
      .wr_addr (buf_addr),
      .wr_data (pair),
      .rd_en   (buf_rd),
      .rd_addr (buf_addr),
      .rd_data (buf_data)
   );

   // configuration writes and position stepping
   always_comb begin
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      first_in = first_ff;
      if (csr_we && (csr_index == REG_ROW_COUNT || csr_index == REG_COLUMN_COUNT)) begin
         if (csr_index == REG_ROW_COUNT) begin
            rows_in = (ROW_BITS'(csr_wdata) > ROW_BITS'(ROW_LIMIT))
                      ? ROW_BITS'(ROW_LIMIT) : ROW_BITS'(csr_wdata);
         end else begin
            cols_in = (COL_BITS'(csr_wdata) > COL_BITS'(MAX_COLUMNS))
                      ? COL_BITS'(MAX_COLUMNS) : COL_BITS'(csr_wdata);
         end
         row_in   = '0;
         col_in   = '0;
         first_in = '0;
      end else if (accept) begin
         if (!odd_col) begin
            first_in = sample;
         end
         if (col_ff + COL_BITS'(1) >= cols_ff) begin
            col_in = '0;
            row_in = (row_ff + ROW_BITS'(1) >= rows_ff) ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   // stage 1 and output register
   always_comb begin
      s1_valid_in     = s1_valid_ff;
      s1_pair_in      = s1_pair_ff;
      s1_row_done_in  = s1_row_done_ff;
      s1_mat_done_in  = s1_mat_done_ff;
      out_valid_in    = out_valid_ff;
      out_avg_in      = out_avg_ff;
      out_row_done_in = out_row_done_ff;
      out_mat_done_in = out_mat_done_ff;

      sum4   = {buf_data[PAIR_BITS-1], buf_data} + {s1_pair_ff[PAIR_BITS-1], s1_pair_ff};
      // bias negative sums so the shift truncates toward zero
      biased = sum4 + (sum4[SUM_BITS-1] ? SUM_BITS'(3) : SUM_BITS'(0));

      if (advance) begin
         out_valid_in    = s1_valid_ff;
         out_avg_in      = biased[SUM_BITS-1:2];
         out_row_done_in = s1_row_done_ff;
         out_mat_done_in = s1_mat_done_ff;
         s1_valid_in     = buf_rd;
         s1_pair_in      = pair;
         s1_row_done_in  = row_done;
         s1_mat_done_in  = row_done && (row_ff == last_row);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= ROW_BITS'(ROW_COUNT_RESET);
         cols_ff      <= COL_BITS'(COLUMN_COUNT_RESET);
         row_ff       <= '0;
         col_ff       <= '0;
         first_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         first_ff     <= first_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pair_ff      <= s1_pair_in;
      s1_row_done_ff  <= s1_row_done_in;
      s1_mat_done_ff  <= s1_mat_done_in;
      out_avg_ff      <= out_avg_in;
      out_row_done_ff <= out_row_done_in;
      out_mat_done_ff <= out_mat_done_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = DATA_BYTES_BITS'(out_avg_ff);
   assign rsp_tlast  = out_row_done_ff;
   assign rsp_tuser  = out_mat_done_ff;

endmodule
